@@ rtl/pla_pkg.sv @@
`default_nettype none

package pla_pkg;

  localparam int unsigned CoordW   = 32;
  localparam int unsigned StampW   = 32;
  localparam int unsigned LenW     = 64;
  localparam int unsigned SquareW  = 2 * CoordW;
  // Radicand wide enough for the sum of three squares, kept even for 2-bit digits.
  localparam int unsigned RadW     = SquareW + 2;
  localparam int unsigned RootW    = RadW / 2;
  localparam int unsigned RemW     = RootW + 1;
  localparam int unsigned RootSteps = RootW;
  localparam int unsigned StepCntW = $clog2(RootSteps);
  localparam int unsigned NumLanes = 2;

  localparam int unsigned LanePlanar  = 0;
  localparam int unsigned LaneSpatial = 1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_SQ_X,
    ST_SQ_Y,
    ST_SQ_Z,
    ST_SUM,
    ST_ROOT,
    ST_ACCUM,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    SEL_X,
    SEL_Y,
    SEL_Z
  } axis_e;

  typedef struct packed {
    logic  load;       // capture sample, form axis differences
    logic  clear;      // restart the track
    logic  square;     // square one axis difference
    axis_e axis;
    logic  sum_planar; // form planar radicand
    logic  sum_spatial;// form spatial radicand, reset root lanes
    logic  root_step;  // one digit of both roots
    logic  accum;      // add roots to running lengths
    logic  out_load;   // fill output word
    logic  first;
  } cmd_t;

  typedef struct packed {
    logic root_last;
  } sts_t;

endpackage

`default_nettype wire

@@ rtl/pla_ctrl.sv @@
`default_nettype none

module pla_ctrl (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            in_valid_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  input  wire            out_stall_i,
  input  wire pla_pkg::sts_t sts_i,
  output pla_pkg::cmd_t  cmd_o
);
  import pla_pkg::*;

  state_e state_q, state_d;
  logic   started_q, started_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;
  logic   out_free;

  assign accept   = in_valid_i && (state_q == ST_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (accept) state_d = started_q ? ST_SQ_X : ST_CLEAR;
      ST_CLEAR: state_d = ST_DONE;
      ST_SQ_X:  state_d = ST_SQ_Y;
      ST_SQ_Y:  state_d = ST_SQ_Z;
      ST_SQ_Z:  state_d = ST_SUM;
      ST_SUM:   state_d = ST_ROOT;
      ST_ROOT:  if (sts_i.root_last) state_d = ST_ACCUM;
      ST_ACCUM: state_d = ST_DONE;
      ST_DONE:  if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.axis = SEL_X;
    cmd_o.load = accept;
    unique case (state_q)
      ST_IDLE:  ;
      ST_CLEAR: cmd_o.clear = 1'b1;
      ST_SQ_X: begin
        cmd_o.square = 1'b1;
        cmd_o.axis   = SEL_X;
      end
      ST_SQ_Y: begin
        cmd_o.square = 1'b1;
        cmd_o.axis   = SEL_Y;
      end
      ST_SQ_Z: begin
        cmd_o.square     = 1'b1;
        cmd_o.axis       = SEL_Z;
        cmd_o.sum_planar = 1'b1;
      end
      ST_SUM:   cmd_o.sum_spatial = 1'b1;
      ST_ROOT:  cmd_o.root_step = 1'b1;
      ST_ACCUM: cmd_o.accum = 1'b1;
      ST_DONE: begin
        cmd_o.out_load = out_free;
        cmd_o.first    = !started_q;
      end
      default:  ;
    endcase
  end

  // Track starts once the first word has been handed to the output.
  assign started_d   = started_q || (state_q == ST_DONE && out_free);
  assign out_valid_d = cmd_o.out_load || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      started_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      started_q   <= started_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

@@ rtl/pla_dpath.sv @@
`default_nettype none

module pla_dpath (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire pla_pkg::cmd_t              cmd_i,
  output pla_pkg::sts_t                   sts_o,
  input  wire  [pla_pkg::CoordW-1:0]      pos_x_i,
  input  wire  [pla_pkg::CoordW-1:0]      pos_y_i,
  input  wire  [pla_pkg::CoordW-1:0]      pos_z_i,
  input  wire  [pla_pkg::StampW-1:0]      stamp_sec_i,
  output logic [pla_pkg::LenW-1:0]        length_planar_o,
  output logic [pla_pkg::LenW-1:0]        length_spatial_o,
  output logic [pla_pkg::StampW-1:0]      elapsed_sec_o,
  output logic                            first_sample_o
);
  import pla_pkg::*;

  logic [CoordW-1:0]  last_x_q, last_y_q, last_z_q;
  logic [CoordW-1:0]  dx_q, dy_q, dz_q;
  logic [CoordW-1:0]  dx_d, dy_d, dz_d;
  logic [StampW-1:0]  stamp_q, start_q;
  logic [CoordW-1:0]  mul_op;
  logic [SquareW-1:0] mul_res;
  logic [SquareW-1:0] sqx_q, sqy_q, sqz_q;
  logic [RadW-1:0]    rad_q [NumLanes];
  logic [RadW-1:0]    rad_d [NumLanes];
  logic [RootW-1:0]   root_q [NumLanes];
  logic [RootW-1:0]   root_d [NumLanes];
  logic [RemW-1:0]    rem_q [NumLanes];
  logic [RemW-1:0]    rem_d [NumLanes];
  logic [StepCntW-1:0] cnt_q;
  logic [LenW-1:0]    total_q [NumLanes];
  logic [LenW-1:0]    total_d [NumLanes];
  logic [LenW:0]      total_sum [NumLanes];
  logic [LenW-1:0]    len_p_q, len_s_q;
  logic [StampW-1:0]  elapsed_q;
  logic               first_q;

  function automatic logic [CoordW-1:0] abs_diff(logic [CoordW-1:0] a, logic [CoordW-1:0] b);
    logic [CoordW:0] d;
    d = {a[CoordW-1], a} - {b[CoordW-1], b};
    if (d[CoordW]) d = -d;
    return d[CoordW-1:0];
  endfunction

  assign dx_d = abs_diff(pos_x_i, last_x_q);
  assign dy_d = abs_diff(pos_y_i, last_y_q);
  assign dz_d = abs_diff(pos_z_i, last_z_q);

  // Capture the sample; the previous position is only needed for the differences.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      last_x_q <= pos_x_i;
      last_y_q <= pos_y_i;
      last_z_q <= pos_z_i;
      dx_q     <= dx_d;
      dy_q     <= dy_d;
      dz_q     <= dz_d;
      stamp_q  <= stamp_sec_i;
    end
  end

  // One shared squarer, one axis per cycle.
  always_comb begin
    case (cmd_i.axis)
      SEL_X:   mul_op = dx_q;
      SEL_Y:   mul_op = dy_q;
      SEL_Z:   mul_op = dz_q;
      default: mul_op = dx_q;
    endcase
  end

  assign mul_res = SquareW'(mul_op) * SquareW'(mul_op);

  always_ff @(posedge clk_i) begin
    if (cmd_i.square) begin
      case (cmd_i.axis)
        SEL_X:   sqx_q <= mul_res;
        SEL_Y:   sqy_q <= mul_res;
        SEL_Z:   sqz_q <= mul_res;
        default: sqx_q <= mul_res;
      endcase
    end
  end

  // Restoring square root, two radicand bits per step, both lanes in lockstep.
  always_comb begin
    logic [RemW+1:0] shifted;
    logic [RemW+1:0] trial;
    logic [RemW+1:0] diff;
    for (int i = 0; i < NumLanes; i++) begin
      rad_d[i]  = rad_q[i];
      root_d[i] = root_q[i];
      rem_d[i]  = rem_q[i];
      shifted   = {rem_q[i], rad_q[i][RadW-1 -: 2]};
      trial     = {1'b0, root_q[i], 2'b01};
      diff      = shifted - trial;
      if (cmd_i.root_step) begin
        rad_d[i] = {rad_q[i][RadW-3:0], 2'b00};
        if (shifted >= trial) begin
          rem_d[i]  = diff[RemW-1:0];
          root_d[i] = {root_q[i][RootW-2:0], 1'b1};
        end else begin
          rem_d[i]  = shifted[RemW-1:0];
          root_d[i] = {root_q[i][RootW-2:0], 1'b0};
        end
      end
    end
    if (cmd_i.sum_planar) begin
      rad_d[LanePlanar] = RadW'(sqx_q) + RadW'(sqy_q);
    end
    if (cmd_i.sum_spatial) begin
      rad_d[LaneSpatial] = rad_q[LanePlanar] + RadW'(sqz_q);
      for (int i = 0; i < NumLanes; i++) begin
        root_d[i] = '0;
        rem_d[i]  = '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NumLanes; i++) begin
      rad_q[i]  <= rad_d[i];
      root_q[i] <= root_d[i];
      rem_q[i]  <= rem_d[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.sum_spatial) begin
      cnt_q <= '0;
    end else if (cmd_i.root_step) begin
      cnt_q <= cnt_q + 1'b1;
    end
  end

  assign sts_o.root_last = (cnt_q == StepCntW'(RootSteps - 1));

  // Saturating running lengths.
  always_comb begin
    for (int i = 0; i < NumLanes; i++) begin
      total_sum[i] = {1'b0, total_q[i]} + (LenW + 1)'(root_q[i]);
      total_d[i]   = total_sum[i][LenW] ? '1 : total_sum[i][LenW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clear) begin
      for (int i = 0; i < NumLanes; i++) total_q[i] <= '0;
      start_q <= stamp_q;
    end else if (cmd_i.accum) begin
      for (int i = 0; i < NumLanes; i++) total_q[i] <= total_d[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      len_p_q   <= total_q[LanePlanar];
      len_s_q   <= total_q[LaneSpatial];
      elapsed_q <= stamp_q - start_q;
      first_q   <= cmd_i.first;
    end
  end

  assign length_planar_o  = len_p_q;
  assign length_spatial_o = len_s_q;
  assign elapsed_sec_o    = elapsed_q;
  assign first_sample_o   = first_q;

endmodule

`default_nettype wire

@@ rtl/path_length_accumulator_core.sv @@
// Path length accumulator.
// Input channel: one word per position sample (x, y, z as signed Q16.16,
// plus a whole-second timestamp), handed over on in_valid_i while
// in_stall_o is low. Output channel: one word per sample with both running
// lengths (unsigned Q48.16, saturating), elapsed seconds since the first
// sample (mod 2^32) and a flag marking the sample that started the track.
// The first sample after reset only records position and start time; its
// word carries zero lengths and zero elapsed time. Every later sample
// squares the three axis steps on one shared 32x32 multiplier, forms both
// radicands, then runs two 2-bit-per-cycle square root lanes side by side,
// and adds the roots into the running lengths. Only one sample is in work
// at a time: a new one is accepted only after the word of the last has
// gone to the output register.
// The output word sits in a register: a new sample is accepted while an
// earlier word still waits on out_stall_i, and a finished word holds in the
// controller until the output register is free.
// Reset (rst_ni low, asynchronous) drops the track; the next sample starts it.
`default_nettype none

module path_length_accumulator_core (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          in_valid_i,
  output logic                         in_stall_o,
  input  wire  [pla_pkg::CoordW-1:0]   pos_x_i,
  input  wire  [pla_pkg::CoordW-1:0]   pos_y_i,
  input  wire  [pla_pkg::CoordW-1:0]   pos_z_i,
  input  wire  [pla_pkg::StampW-1:0]   stamp_sec_i,
  output logic                         out_valid_o,
  input  wire                          out_stall_i,
  output logic [pla_pkg::LenW-1:0]     length_planar_o,
  output logic [pla_pkg::LenW-1:0]     length_spatial_o,
  output logic [pla_pkg::StampW-1:0]   elapsed_sec_o,
  output logic                         first_sample_o
);
  import pla_pkg::*;

  // Commands down to the datapath, status back up.
  cmd_t cmd;
  sts_t sts;

  pla_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Axis differences, shared squarer, root lanes, running lengths, output word.
  pla_dpath u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .pos_x_i          (pos_x_i),
    .pos_y_i          (pos_y_i),
    .pos_z_i          (pos_z_i),
    .stamp_sec_i      (stamp_sec_i),
    .length_planar_o  (length_planar_o),
    .length_spatial_o (length_spatial_o),
    .elapsed_sec_o    (elapsed_sec_o),
    .first_sample_o   (first_sample_o)
  );

endmodule

`default_nettype wire

@@ test/tb.sv @@
`default_nettype none

module tb;

  import pla_pkg::*;

  localparam int unsigned RandomSamples = 1600;

  typedef struct {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [CoordW-1:0] z;
    logic [StampW-1:0] stamp;
  } sample_t;

  typedef struct {
    logic [LenW-1:0]   planar;
    logic [LenW-1:0]   spatial;
    logic [StampW-1:0] elapsed;
    logic              first;
  } totals_t;

  // DUT connections; every input starts at a known value.
  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [CoordW-1:0] pos_x_i = '0;
  logic [CoordW-1:0] pos_y_i = '0;
  logic [CoordW-1:0] pos_z_i = '0;
  logic [StampW-1:0] stamp_sec_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [LenW-1:0]   length_planar_o;
  logic [LenW-1:0]   length_spatial_o;
  logic [StampW-1:0] elapsed_sec_o;
  logic              first_sample_o;

  path_length_accumulator_core dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .pos_x_i          (pos_x_i),
    .pos_y_i          (pos_y_i),
    .pos_z_i          (pos_z_i),
    .stamp_sec_i      (stamp_sec_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .length_planar_o  (length_planar_o),
    .length_spatial_o (length_spatial_o),
    .elapsed_sec_o    (elapsed_sec_o),
    .first_sample_o   (first_sample_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  sample_t     queued_samples[$];
  totals_t     expected_totals[$];
  int unsigned samples_total = 0;
  int unsigned samples_taken = 0;
  int unsigned fail_cnt = 0;
  logic        quiet = 1'b0;

  // Track state mirrored from the block: position of the previous sample,
  // the two running lengths and the stamp that opened the track.
  logic              track_open = 1'b0;
  logic [CoordW-1:0] prev_x = '0;
  logic [CoordW-1:0] prev_y = '0;
  logic [CoordW-1:0] prev_z = '0;
  logic [LenW-1:0]   run_planar = '0;
  logic [LenW-1:0]   run_spatial = '0;
  logic [StampW-1:0] origin_stamp = '0;

  // Magnitude of a signed coordinate step; never exceeds 2^32 - 1.
  function automatic logic [CoordW-1:0] step_mag(logic [CoordW-1:0] a, logic [CoordW-1:0] b);
    logic signed [CoordW:0] d;
    d = $signed({a[CoordW-1], a}) - $signed({b[CoordW-1], b});
    if (d < 0) d = -d;
    return d[CoordW-1:0];
  endfunction

  // Floor square root of a radicand below 2^66, one root bit per pass.
  function automatic logic [33:0] floor_root(logic [67:0] v);
    logic [33:0] root;
    logic [33:0] cand;
    logic [67:0] sq;
    root = '0;
    for (int b = 33; b >= 0; b--) begin
      cand = root | (34'd1 << b);
      sq = {34'd0, cand} * {34'd0, cand};
      if (sq <= v) root = cand;
    end
    return root;
  endfunction

  function automatic logic [LenW-1:0] sat_sum(logic [LenW-1:0] a, logic [33:0] b);
    logic [LenW:0] s;
    s = {1'b0, a} + {31'd0, b};
    return s[LenW] ? '1 : s[LenW-1:0];
  endfunction

  // Advance the mirrored track by one accepted sample and queue its word.
  task automatic advance_track(sample_t s);
    totals_t     t;
    logic [67:0] dx2, dy2, dz2, planar_sq, spatial_sq;
    if (!track_open) begin
      // Opening sample: remember where and when, report nothing travelled.
      track_open   = 1'b1;
      run_planar   = '0;
      run_spatial  = '0;
      origin_stamp = s.stamp;
      t.first      = 1'b1;
      t.elapsed    = '0;
    end else begin
      dx2 = {36'd0, step_mag(s.x, prev_x)} * {36'd0, step_mag(s.x, prev_x)};
      dy2 = {36'd0, step_mag(s.y, prev_y)} * {36'd0, step_mag(s.y, prev_y)};
      dz2 = {36'd0, step_mag(s.z, prev_z)} * {36'd0, step_mag(s.z, prev_z)};
      planar_sq   = dx2 + dy2;
      spatial_sq  = planar_sq + dz2;
      run_planar  = sat_sum(run_planar, floor_root(planar_sq));
      run_spatial = sat_sum(run_spatial, floor_root(spatial_sq));
      t.first     = 1'b0;
      t.elapsed   = s.stamp - origin_stamp;
    end
    prev_x    = s.x;
    prev_y    = s.y;
    prev_z    = s.z;
    t.planar  = run_planar;
    t.spatial = run_spatial;
    expected_totals.push_back(t);
  endtask

  // Idle length: mostly none or short, now and then a long one; none at all
  // while a quiet stretch is running.
  function automatic int unsigned pick_pause();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 16);
    return $urandom_range(40, 200);
  endfunction

  // Switch at random between idling and back-to-back stretches.
  always begin
    repeat ($urandom_range(200, 1500)) @(posedge clk_i);
    quiet <= ($urandom_range(0, 3) == 0);
  end

  // Input driver: hold the word while stalled, otherwise advance to the next
  // queued sample or drop valid for the rest of the current gap.
  int unsigned send_gap = 0;
  sample_t     next_sample;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        advance_track('{x: pos_x_i, y: pos_y_i, z: pos_z_i, stamp: stamp_sec_i});
        samples_taken++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (send_gap != 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (queued_samples.size() != 0) begin
          next_sample = queued_samples.pop_front();
          pos_x_i     <= next_sample.x;
          pos_y_i     <= next_sample.y;
          pos_z_i     <= next_sample.z;
          stamp_sec_i <= next_sample.stamp;
          in_valid_i  <= 1'b1;
          send_gap = pick_pause();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Output monitor: check every accepted word against the oldest expected
  // totals, then pick the stall for the next cycle.
  int unsigned stall_left = 0;
  totals_t     want;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_totals.size() == 0) begin
          $display("%0t: unexpected word: planar %h spatial %h elapsed %h first %b",
                   $time, length_planar_o, length_spatial_o, elapsed_sec_o,
                   first_sample_o);
          fail_cnt++;
        end else begin
          want = expected_totals.pop_front();
          if (length_planar_o !== want.planar) begin
            $display("%0t: length_planar mismatch: expected %h, got %h",
                     $time, want.planar, length_planar_o);
            fail_cnt++;
          end
          if (length_spatial_o !== want.spatial) begin
            $display("%0t: length_spatial mismatch: expected %h, got %h",
                     $time, want.spatial, length_spatial_o);
            fail_cnt++;
          end
          if (elapsed_sec_o !== want.elapsed) begin
            $display("%0t: elapsed_sec mismatch: expected %h, got %h",
                     $time, want.elapsed, elapsed_sec_o);
            fail_cnt++;
          end
          if (first_sample_o !== want.first) begin
            $display("%0t: first_sample mismatch: expected %b, got %b",
                     $time, want.first, first_sample_o);
            fail_cnt++;
          end
        end
      end
      if (stall_left != 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
        stall_left = pick_pause();
      end
    end
  end

  task automatic add_sample(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic [31:0] s);
    queued_samples.push_back('{x: x, y: y, z: z, stamp: s});
    samples_total++;
  endtask

  // Signed walk step with a magnitude anywhere from zero to full range.
  function automatic logic [31:0] walk_step();
    logic [31:0] mag;
    mag = $urandom() >> $urandom_range(0, 31);
    return $urandom_range(0, 1) ? -mag : mag;
  endfunction

  function automatic logic [31:0] corner_coord();
    case ($urandom_range(0, 4))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return 32'h0000_0001;
    endcase
  endfunction

  localparam logic [31:0] CMin = 32'h8000_0000;
  localparam logic [31:0] CMax = 32'h7fff_ffff;
  localparam logic [31:0] Metre = 32'h0001_0000;

  initial begin
    logic [31:0] wx, wy, wz, ws;
    int unsigned r;

    // Directed part. The opening sample sits near the top of the stamp range
    // so later stamps wrap forward, and go backwards further down.
    add_sample(CMin, CMax, 32'd0, 32'hffff_fff0);
    add_sample(CMin, CMax, 32'd0, 32'hffff_fff0);       // zero step
    add_sample(CMax, CMin, CMin, 32'd5);                // full x/y swing, stamp wraps
    add_sample(CMax, CMin, CMax, 32'd6);                // full z swing only
    add_sample(32'd0, 32'd0, 32'd0, 32'hffff_ffe0);     // stamp behind the start
    add_sample(32'd1, 32'd0, 32'd0, 32'hffff_fff1);     // one LSB in x
    add_sample(32'd1, 32'hffff_ffff, 32'd0, 32'hffff_fff2);
    add_sample(32'd1, 32'hffff_ffff, Metre, 32'hffff_fff3);
    add_sample(32'd3 * Metre, 32'd4 * Metre, Metre, 32'hffff_fff4); // near 3-4-5 step
    add_sample(32'd0, 32'd0, Metre, 32'hffff_fff5);
    add_sample(32'h0001_8000, 32'h0000_4000, 32'h0002_2222, 32'hffff_ffff);
    add_sample(CMin, CMin, CMin, 32'd0);
    add_sample(CMax, CMax, CMax, 32'hffff_ffff);        // largest spatial radicand
    add_sample(CMin, CMin, CMin, 32'h8000_0000);
    add_sample(32'hffff_0000, 32'h0001_0000, 32'hffff_ffff, 32'h7fff_ffff);
    add_sample(32'h0001_0000, 32'hffff_0000, 32'd1, 32'h7fff_fff0);
    add_sample(32'h5555_5555, 32'haaaa_aaaa, 32'h3333_3333, 32'hffff_fff0);
    add_sample(32'haaaa_aaaa, 32'h5555_5555, 32'hcccc_cccc, 32'h0000_0000);

    // Random part: mostly walks with random steps, some scattered jumps,
    // corner positions and wild stamps.
    wx = $urandom();
    wy = $urandom();
    wz = $urandom();
    ws = $urandom();
    for (int i = 0; i < RandomSamples; i++) begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        wx += walk_step();
        wy += walk_step();
        wz += ($urandom_range(0, 3) == 0) ? 32'd0 : walk_step();
        ws += $urandom_range(0, 3);
      end else if (r < 80) begin
        wx = $urandom();
        wy = $urandom();
        wz = $urandom();
        ws += $urandom_range(0, 100);
      end else if (r < 90) begin
        wx = corner_coord();
        wy = corner_coord();
        wz = corner_coord();
        ws += 1;
      end else begin
        wx = $urandom();
        wy = $urandom();
        wz = $urandom();
        ws = $urandom();
      end
      add_sample(wx, wy, wz, ws);
    end

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (samples_taken < samples_total || expected_totals.size() != 0) @(posedge clk_i);
    // Keep watching for any stray word before the verdict.
    repeat (64) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Timeout, several times the slowest legal run.
  initial begin
    #60_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

`default_nettype wire

@@ files.f @@
rtl/pla_pkg.sv
rtl/pla_ctrl.sv
rtl/pla_dpath.sv
rtl/path_length_accumulator_core.sv
test/tb.sv
